>>> hdl/hts_pkg.sv
`default_nettype none

package hts_pkg;

    // Default width of temperatures and setpoints, in 1/16 degree C.
    localparam int TEMP_WIDTH_DEFAULT = 12;

    // Configuration port geometry.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Fixed field widths.
    localparam int HYST_WIDTH = 8;
    localparam int AGE_WIDTH  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETPOINT            = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HYSTERESIS          = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALARM_THRESHOLD     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STALE_TIMEOUT       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE_FLAG         = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_FROM_INPUT   = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETPOINT_FROM_INPUT = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEDICATED_SENSOR    = 3'd7;

    // Register reset values.
    localparam int                    SETPOINT_RESET        = 320;
    localparam logic [HYST_WIDTH-1:0] HYSTERESIS_RESET      = 8'd8;
    localparam int                    ALARM_THRESHOLD_RESET = 1280;
    localparam logic [AGE_WIDTH-1:0]  STALE_TIMEOUT_RESET   = 16'd60;

    // Reason for the relay decision of a tick.
    typedef enum logic [2:0] {
        CAUSE_CONTROL  = 3'd0,
        CAUSE_INACTIVE = 3'd1,
        CAUSE_NO_SENSOR = 3'd2,
        CAUSE_NO_TEMP  = 3'd3,
        CAUSE_STALE    = 3'd4,
        CAUSE_ALARM    = 3'd5
    } cause_t;

    // Last published mode.
    localparam logic [1:0] MODE_ACTIVE  = 2'd1;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

endpackage

`default_nettype wire

>>> hdl/hysteresis_thermostat_with_safety.sv
`default_nettype none

// Bang-bang thermostat with hysteresis and safety interlocks. Each input word is
// one one-second tick and yields exactly one result word. The relay is forced
// off when the block is inactive, the dedicated sensor was never read, no
// temperature is available, the reading is stale or the temperature reaches the
// alarm threshold; otherwise on/off control runs against the setpoint with a
// half-band of hysteresis either side, and change-only publication flags are
// raised. The block takes one tick per clock while results are taken: a word
// passes an input register and then a result register, and the input register
// can take one more word while a finished result waits.
// Configuration registers are written through their own port, which is
// always ready; write them only while no tick is in flight.
module hysteresis_thermostat_with_safety
    import hts_pkg::*;
#(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // Configuration write channel.
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,

    // Input channel.
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [TEMP_WIDTH-1:0] temperature,
    input  wire logic                        temp_valid,
    input  wire logic                        sensor_seen,
    input  wire logic [AGE_WIDTH-1:0]        sensor_age,
    input  wire logic                        active_level,
    input  wire logic signed [TEMP_WIDTH-1:0] external_setpoint,

    // Result channel.
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             relay_on,
    output logic                             relay_changed,
    output logic [2:0]                       cause,
    output logic signed [TEMP_WIDTH-1:0]     used_setpoint,
    output logic                             publish_temp,
    output logic                             publish_setpoint,
    output logic                             publish_mode
);

    // Doubled values with the hysteresis band added need two extra bits.
    localparam int CW = TEMP_WIDTH + 2;
    // Differences against the last published value need one extra bit.
    localparam int DW = TEMP_WIDTH + 1;

    // Configuration registers.
    logic signed [TEMP_WIDTH-1:0] setpoint_reg;
    logic [HYST_WIDTH-1:0]        hysteresis_reg;
    logic signed [TEMP_WIDTH-1:0] alarm_threshold_reg;
    logic [AGE_WIDTH-1:0]         stale_timeout_reg;
    logic                         enable_flag_reg;
    logic                         active_from_input_reg;
    logic                         setpoint_from_input_reg;
    logic                         dedicated_sensor_reg;

    // Input register.
    logic                         in_valid_reg;
    logic signed [TEMP_WIDTH-1:0] temperature_reg;
    logic                         temp_valid_reg;
    logic                         sensor_seen_reg;
    logic [AGE_WIDTH-1:0]         sensor_age_reg;
    logic                         active_level_reg;
    logic signed [TEMP_WIDTH-1:0] external_setpoint_reg;

    // Controller state.
    logic                         relay_state_reg;
    logic signed [TEMP_WIDTH-1:0] last_sent_temp_reg;
    logic                         temp_sent_valid_reg;
    logic signed [TEMP_WIDTH-1:0] last_sent_setpoint_reg;
    logic                         setpoint_sent_valid_reg;
    logic [1:0]                   last_sent_mode_reg;

    // Result register.
    logic                         out_valid_reg;
    logic                         relay_on_reg;
    logic                         relay_changed_reg;
    cause_t                       cause_reg;
    logic signed [TEMP_WIDTH-1:0] used_setpoint_reg;
    logic                         publish_temp_reg;
    logic                         publish_setpoint_reg;
    logic                         publish_mode_reg;

    // Next values.
    logic                         relay_next;
    cause_t                       cause_next;
    logic signed [TEMP_WIDTH-1:0] sp_next;
    logic                         publish_temp_next;
    logic                         publish_setpoint_next;
    logic                         publish_mode_next;

    // Datapath intermediates.
    logic                         active;
    logic                         stale;
    logic signed [CW-1:0]         temp_x2;
    logic signed [CW-1:0]         sp_x2;
    logic signed [CW-1:0]         hyst_ext;
    logic signed [CW-1:0]         on_limit;
    logic signed [CW-1:0]         off_limit;
    logic signed [DW-1:0]         temp_diff;
    logic signed [DW-1:0]         sp_diff;
    logic                         temp_near;
    logic                         sp_near;

    // Handshake: each stage advances when the one after it is free.
    logic res_ready;
    logic res_load;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;
    assign res_load  = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg            <= TEMP_WIDTH'(SETPOINT_RESET);
            hysteresis_reg          <= HYSTERESIS_RESET;
            alarm_threshold_reg     <= TEMP_WIDTH'(ALARM_THRESHOLD_RESET);
            stale_timeout_reg       <= STALE_TIMEOUT_RESET;
            enable_flag_reg         <= 1'b1;
            active_from_input_reg   <= 1'b0;
            setpoint_from_input_reg <= 1'b0;
            dedicated_sensor_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SETPOINT:            setpoint_reg <= cfg_data[TEMP_WIDTH-1:0];
                REG_HYSTERESIS:          hysteresis_reg <= cfg_data[HYST_WIDTH-1:0];
                REG_ALARM_THRESHOLD:     alarm_threshold_reg <= cfg_data[TEMP_WIDTH-1:0];
                REG_STALE_TIMEOUT:       stale_timeout_reg <= cfg_data[AGE_WIDTH-1:0];
                REG_ENABLE_FLAG:         enable_flag_reg <= cfg_data[0];
                REG_ACTIVE_FROM_INPUT:   active_from_input_reg <= cfg_data[0];
                REG_SETPOINT_FROM_INPUT: setpoint_from_input_reg <= cfg_data[0];
                REG_DEDICATED_SENSOR:    dedicated_sensor_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // Input register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register: payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            temperature_reg       <= temperature;
            temp_valid_reg        <= temp_valid;
            sensor_seen_reg       <= sensor_seen;
            sensor_age_reg        <= sensor_age;
            active_level_reg      <= active_level;
            external_setpoint_reg <= external_setpoint;
        end
    end

    // Source selection and the doubled comparison operands.
    always_comb
    begin
        active   = active_from_input_reg ? active_level_reg : enable_flag_reg;
        sp_next  = setpoint_from_input_reg ? external_setpoint_reg : setpoint_reg;
        stale    = (stale_timeout_reg != '0) && (sensor_age_reg >= stale_timeout_reg);
        temp_x2  = CW'(temperature_reg) <<< 1;
        sp_x2    = CW'(sp_next) <<< 1;
        hyst_ext = CW'($signed({1'b0, hysteresis_reg}));
        on_limit  = sp_x2 - hyst_ext;
        off_limit = sp_x2 + hyst_ext;
    end

    // Safety priority chain: the first failing check decides the cause.
    always_comb
    begin
        priority if (!active)
        begin
            cause_next = CAUSE_INACTIVE;
        end
        else if (dedicated_sensor_reg && !sensor_seen_reg)
        begin
            cause_next = CAUSE_NO_SENSOR;
        end
        else if (!dedicated_sensor_reg && !temp_valid_reg)
        begin
            cause_next = CAUSE_NO_TEMP;
        end
        else if (dedicated_sensor_reg && stale)
        begin
            cause_next = CAUSE_STALE;
        end
        else if (temperature_reg >= alarm_threshold_reg)
        begin
            cause_next = CAUSE_ALARM;
        end
        else
        begin
            cause_next = CAUSE_CONTROL;
        end
    end

    // Deadband checks against the last published values.
    always_comb
    begin
        temp_diff = DW'(temperature_reg) - DW'(last_sent_temp_reg);
        sp_diff   = DW'(sp_next) - DW'(last_sent_setpoint_reg);
        temp_near = (temp_diff == '0) || (temp_diff == DW'(1)) || (temp_diff == '1);
        sp_near   = (sp_diff == '0) || (sp_diff == DW'(1)) || (sp_diff == '1);
    end

    // Relay decision and publication flags.
    always_comb
    begin
        relay_next            = 1'b0;
        publish_temp_next     = 1'b0;
        publish_setpoint_next = 1'b0;
        publish_mode_next     = 1'b0;
        if (cause_next == CAUSE_CONTROL)
        begin
            if (!relay_state_reg)
            begin
                relay_next = (temp_x2 < on_limit);
            end
            else
            begin
                relay_next = !(temp_x2 > off_limit);
            end
            publish_temp_next     = !temp_sent_valid_reg || !temp_near;
            publish_setpoint_next = !setpoint_sent_valid_reg || !sp_near;
            publish_mode_next     = (last_sent_mode_reg != MODE_ACTIVE);
        end
    end

    // Controller state and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_state_reg         <= 1'b0;
            last_sent_temp_reg      <= '0;
            temp_sent_valid_reg     <= 1'b0;
            last_sent_setpoint_reg  <= '0;
            setpoint_sent_valid_reg <= 1'b0;
            last_sent_mode_reg      <= MODE_UNKNOWN;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (res_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (res_load)
            begin
                relay_state_reg <= relay_next;
                if (publish_temp_next)
                begin
                    last_sent_temp_reg  <= temperature_reg;
                    temp_sent_valid_reg <= 1'b1;
                end
                if (publish_setpoint_next)
                begin
                    last_sent_setpoint_reg  <= sp_next;
                    setpoint_sent_valid_reg <= 1'b1;
                end
                if (publish_mode_next)
                begin
                    last_sent_mode_reg <= MODE_ACTIVE;
                end
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            relay_on_reg         <= relay_next;
            relay_changed_reg    <= relay_next != relay_state_reg;
            cause_reg            <= cause_next;
            used_setpoint_reg    <= sp_next;
            publish_temp_reg     <= publish_temp_next;
            publish_setpoint_reg <= publish_setpoint_next;
            publish_mode_reg     <= publish_mode_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign relay_on         = relay_on_reg;
    assign relay_changed    = relay_changed_reg;
    assign cause            = cause_reg;
    assign used_setpoint    = used_setpoint_reg;
    assign publish_temp     = publish_temp_reg;
    assign publish_setpoint = publish_setpoint_reg;
    assign publish_mode     = publish_mode_reg;

    // A forced-off result drives the relay off and publishes nothing.
    a_forced_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cause_reg != CAUSE_CONTROL) |->
            (!relay_on_reg && !publish_temp_reg && !publish_setpoint_reg
             && !publish_mode_reg))
        else $error("forced-off result drives relay or publishes");

    // The waiting result always shows the relay state the controller holds.
    a_relay_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (relay_on_reg == relay_state_reg))
        else $error("result relay differs from controller state");

    // A published temperature leaves the publication record valid.
    a_temp_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && publish_temp_reg) |-> temp_sent_valid_reg)
        else $error("temperature published without being recorded");

    // A published mode leaves the record at the active mode.
    a_mode_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && publish_mode_reg) |-> (last_sent_mode_reg == MODE_ACTIVE))
        else $error("mode published without being recorded");

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hts_pkg::*;

    localparam int TW         = TEMP_WIDTH_DEFAULT;
    localparam int TEMP_MAX   = (1 << (TW - 1)) - 1;
    localparam int TEMP_MIN   = -(1 << (TW - 1));
    localparam int LONG_HOLD  = 150;
    localparam int QUIET_MAX  = 2000;

    typedef logic signed [TW-1:0] temp_t;

    // One tick as offered on the input channel.
    typedef struct packed {
        temp_t                 temperature;
        logic                  temp_valid;
        logic                  sensor_seen;
        logic [AGE_WIDTH-1:0]  sensor_age;
        logic                  active_level;
        temp_t                 external_setpoint;
    } tick_t;

    // One result word as it should leave the block.
    typedef struct packed {
        logic   relay_on;
        logic   relay_changed;
        cause_t cause;
        temp_t  used_setpoint;
        logic   publish_temp;
        logic   publish_setpoint;
        logic   publish_mode;
    } verdict_t;

    // Contents of the configuration registers.
    typedef struct packed {
        temp_t                  setpoint;
        logic [HYST_WIDTH-1:0]  hysteresis;
        temp_t                  alarm_threshold;
        logic [AGE_WIDTH-1:0]   stale_timeout;
        logic                   enable_flag;
        logic                   active_from_input;
        logic                   setpoint_from_input;
        logic                   dedicated_sensor;
    } settings_t;

    localparam settings_t RESET_SETTINGS = '{
        setpoint:            temp_t'(SETPOINT_RESET),
        hysteresis:          HYSTERESIS_RESET,
        alarm_threshold:     temp_t'(ALARM_THRESHOLD_RESET),
        stale_timeout:       STALE_TIMEOUT_RESET,
        enable_flag:         1'b1,
        active_from_input:   1'b0,
        setpoint_from_input: 1'b0,
        dedicated_sensor:    1'b0
    };

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    temp_t                       temperature = '0;
    logic                        temp_valid = 1'b0;
    logic                        sensor_seen = 1'b0;
    logic [AGE_WIDTH-1:0]        sensor_age = '0;
    logic                        active_level = 1'b0;
    temp_t                       external_setpoint = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        relay_on;
    logic                        relay_changed;
    logic [2:0]                  cause;
    temp_t                       used_setpoint;
    logic                        publish_temp;
    logic                        publish_setpoint;
    logic                        publish_mode;

    // Predictor copy of the registers and of the thermostat state.
    settings_t   settings = RESET_SETTINGS;
    logic        heat_on = 1'b0;
    int          sent_temp = 0;
    logic        sent_temp_known = 1'b0;
    int          sent_setpoint = 0;
    logic        sent_setpoint_known = 1'b0;
    logic [1:0]  sent_mode = MODE_UNKNOWN;

    verdict_t    pending_verdicts[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          idling = 1'b1;
    bit          hold_request = 1'b0;
    int          stall_left = 0;
    int          drift_temp = 0;
    int          drift_sp = SETPOINT_RESET;

    hysteresis_thermostat_with_safety dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .temperature       (temperature),
        .temp_valid        (temp_valid),
        .sensor_seen       (sensor_seen),
        .sensor_age        (sensor_age),
        .active_level      (active_level),
        .external_setpoint (external_setpoint),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .relay_on          (relay_on),
        .relay_changed     (relay_changed),
        .cause             (cause),
        .used_setpoint     (used_setpoint),
        .publish_temp      (publish_temp),
        .publish_setpoint  (publish_setpoint),
        .publish_mode      (publish_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_temp(int v);
        if (v > TEMP_MAX)
            return TEMP_MAX;
        if (v < TEMP_MIN)
            return TEMP_MIN;
        return v;
    endfunction

    // A value counts as moved by two sixteenths or more, or when never published.
    function automatic logic beyond_deadband(int now, int last, logic known);
        return !known || (now - last >= 2) || (now - last <= -2);
    endfunction

    // Works out the result of one tick and advances the thermostat state.
    function automatic verdict_t next_verdict(tick_t w);
        verdict_t v;
        int       temp;
        int       sp;
        int       h;
        logic     active;
        logic     prev;
        cause_t   why;

        temp   = int'(w.temperature);
        sp     = settings.setpoint_from_input ? int'(w.external_setpoint)
                                              : int'(settings.setpoint);
        h      = int'(settings.hysteresis);
        active = settings.active_from_input ? w.active_level : settings.enable_flag;
        prev   = heat_on;

        // Safety interlocks in order of priority.
        if (!active)
            why = CAUSE_INACTIVE;
        else if (settings.dedicated_sensor && !w.sensor_seen)
            why = CAUSE_NO_SENSOR;
        else if (!settings.dedicated_sensor && !w.temp_valid)
            why = CAUSE_NO_TEMP;
        else if (settings.dedicated_sensor && settings.stale_timeout != '0
                 && w.sensor_age >= settings.stale_timeout)
            why = CAUSE_STALE;
        else if (temp >= int'(settings.alarm_threshold))
            why = CAUSE_ALARM;
        else
            why = CAUSE_CONTROL;

        v.publish_temp     = 1'b0;
        v.publish_setpoint = 1'b0;
        v.publish_mode     = 1'b0;

        if (why != CAUSE_CONTROL)
        begin
            heat_on = 1'b0;
        end
        else
        begin
            // Half of the band either side of the setpoint.
            if (!heat_on)
            begin
                if (2 * temp < 2 * sp - h)
                    heat_on = 1'b1;
            end
            else if (2 * temp > 2 * sp + h)
            begin
                heat_on = 1'b0;
            end
            if (beyond_deadband(temp, sent_temp, sent_temp_known))
            begin
                v.publish_temp  = 1'b1;
                sent_temp       = temp;
                sent_temp_known = 1'b1;
            end
            if (beyond_deadband(sp, sent_setpoint, sent_setpoint_known))
            begin
                v.publish_setpoint  = 1'b1;
                sent_setpoint       = sp;
                sent_setpoint_known = 1'b1;
            end
            if (sent_mode != MODE_ACTIVE)
            begin
                v.publish_mode = 1'b1;
                sent_mode      = MODE_ACTIVE;
            end
        end

        v.relay_on      = heat_on;
        v.relay_changed = (heat_on != prev);
        v.cause         = why;
        v.used_setpoint = temp_t'(sp);
        return v;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int gap_len();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tick_t make_tick(int temp, logic tv, logic seen, int age,
                                        logic act, int ext);
        tick_t w;
        w.temperature       = temp_t'(temp);
        w.temp_valid        = tv;
        w.sensor_seen       = seen;
        w.sensor_age        = AGE_WIDTH'(age);
        w.active_level      = act;
        w.external_setpoint = temp_t'(ext);
        return w;
    endfunction

    // Random tick, mostly healthy readings drifting around the setpoint band.
    function automatic tick_t rand_tick();
        tick_t w;
        int    base;
        int    hyst;
        int    stale;
        int    r;

        r = $urandom_range(0, 9);
        if (r < 7)
            drift_sp = clamp_temp(drift_sp + int'($urandom_range(0, 6)) - 3);
        else
            drift_sp = int'($urandom_range(0, 4095)) - 2048;
        w.external_setpoint = temp_t'(drift_sp);

        base = settings.setpoint_from_input ? drift_sp : int'(settings.setpoint);
        hyst = int'(settings.hysteresis);
        r = $urandom_range(0, 9);
        if (r < 4)
            drift_temp = clamp_temp(drift_temp + int'($urandom_range(0, 6)) - 3);
        else if (r < 8)
            drift_temp = clamp_temp(base + int'($urandom_range(0, 2 * hyst + 16))
                                    - (hyst + 8));
        else
            drift_temp = int'($urandom_range(0, 4095)) - 2048;
        w.temperature = temp_t'(drift_temp);

        w.temp_valid   = ($urandom_range(0, 19) != 0);
        w.sensor_seen  = ($urandom_range(0, 19) != 0);
        w.active_level = ($urandom_range(0, 9) != 0);

        // Sensor age mostly fresh, sometimes right at the stale limit.
        stale = int'(settings.stale_timeout);
        r = $urandom_range(0, 9);
        if (r < 6)
            w.sensor_age = (stale > 1) ? AGE_WIDTH'($urandom_range(0, stale - 2)) : '0;
        else if (r < 8)
            w.sensor_age = AGE_WIDTH'(stale + int'($urandom_range(0, 2)) - 1);
        else
            w.sensor_age = AGE_WIDTH'($urandom_range(0, 65535));
        return w;
    endfunction

    function automatic settings_t rand_settings();
        settings_t s;
        int        sp;
        int        r;

        sp = int'($urandom_range(0, 3000)) - 1500;
        s.setpoint = temp_t'(sp);
        r = $urandom_range(0, 9);
        if (r == 0)
            s.hysteresis = '0;
        else if (r == 1)
            s.hysteresis = '1;
        else
            s.hysteresis = HYST_WIDTH'($urandom_range(0, 40));
        if ($urandom_range(0, 9) < 7)
            s.alarm_threshold = temp_t'(clamp_temp(sp + int'($urandom_range(64, 600))));
        else
            s.alarm_threshold = temp_t'($urandom_range(0, 4095));
        case ($urandom_range(0, 4))
            0:       s.stale_timeout = '0;
            1:       s.stale_timeout = AGE_WIDTH'(1);
            2:       s.stale_timeout = '1;
            default: s.stale_timeout = AGE_WIDTH'($urandom_range(2, 200));
        endcase
        s.enable_flag         = ($urandom_range(0, 3) != 0);
        s.active_from_input   = 1'($urandom_range(0, 1));
        s.setpoint_from_input = 1'($urandom_range(0, 1));
        s.dedicated_sensor    = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // Offers one word after a random gap and returns once it is taken.
    task automatic send_word(input tick_t w);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        temperature       <= w.temperature;
        temp_valid        <= w.temp_valid;
        sensor_seen       <= w.sensor_seen;
        sensor_age        <= w.sensor_age;
        active_level      <= w.active_level;
        external_setpoint <= w.external_setpoint;
        in_valid          <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Waits until every expected word is back and the pipeline has emptied.
    // The first edge lets the monitor queue a word taken at the current edge.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(input settings_t s);
        wait_idle();
        write_reg(REG_SETPOINT,            CFG_DATA_WIDTH'(s.setpoint));
        write_reg(REG_HYSTERESIS,          CFG_DATA_WIDTH'(s.hysteresis));
        write_reg(REG_ALARM_THRESHOLD,     CFG_DATA_WIDTH'(s.alarm_threshold));
        write_reg(REG_STALE_TIMEOUT,       CFG_DATA_WIDTH'(s.stale_timeout));
        write_reg(REG_ENABLE_FLAG,         CFG_DATA_WIDTH'(s.enable_flag));
        write_reg(REG_ACTIVE_FROM_INPUT,   CFG_DATA_WIDTH'(s.active_from_input));
        write_reg(REG_SETPOINT_FROM_INPUT, CFG_DATA_WIDTH'(s.setpoint_from_input));
        write_reg(REG_DEDICATED_SENSOR,    CFG_DATA_WIDTH'(s.dedicated_sensor));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Band edges, deadband, interlocks and field extremes with reset settings.
    task automatic test_control_band();
        tick_t w;
        w = make_tick(300, 1'b1, 1'b0, 65535, 1'b0, TEMP_MIN);
        send_word(w);
        send_word(w);
        w.temperature = 301;
        send_word(w);
        // Upper edge of the band keeps the relay on, one step past turns it off.
        w.temperature = 324;
        send_word(w);
        w.temperature = 325;
        send_word(w);
        w.temperature = 316;
        send_word(w);
        w.temperature = 315;
        send_word(w);
        w.temp_valid = 1'b0;
        send_word(w);
        w.temp_valid  = 1'b1;
        w.temperature = 1280;
        send_word(w);
        w.temperature = 1279;
        send_word(w);
        w.temperature = temp_t'(TEMP_MAX);
        send_word(w);
        w = make_tick(TEMP_MIN, 1'b1, 1'b1, 0, 1'b1, TEMP_MAX);
        send_word(w);
    endtask

    // Presence and age checks of the dedicated sensor.
    task automatic test_dedicated_sensor();
        settings_t s;
        tick_t     w;
        s = RESET_SETTINGS;
        s.dedicated_sensor = 1'b1;
        reconfigure(s);
        w = make_tick(300, 1'b0, 1'b0, 0, 1'b1, 0);
        send_word(w);
        w.sensor_seen = 1'b1;
        w.sensor_age  = 60;
        send_word(w);
        // Fresh reading: the generic validity bit no longer matters.
        w.sensor_age = 59;
        send_word(w);
        s.stale_timeout = '0;
        reconfigure(s);
        w.sensor_age = '1;
        send_word(w);
    endtask

    // Active level and setpoint taken from the input word.
    task automatic test_input_selectors();
        settings_t s;
        tick_t     w;
        s = RESET_SETTINGS;
        s.enable_flag         = 1'b0;
        s.active_from_input   = 1'b1;
        s.setpoint_from_input = 1'b1;
        reconfigure(s);
        w = make_tick(0, 1'b1, 1'b0, 0, 1'b0, TEMP_MIN);
        send_word(w);
        w.active_level      = 1'b1;
        w.external_setpoint = temp_t'(TEMP_MAX);
        send_word(w);
        w.external_setpoint = temp_t'(TEMP_MAX - 1);
        send_word(w);
        s.active_from_input = 1'b0;
        reconfigure(s);
        send_word(w);
    endtask

    // Phases of random ticks, each under its own register settings.
    task automatic test_random_phases();
        settings_t s;
        for (int p = 0; p < 12; p++)
        begin
            if (p == 0)
                s = '{setpoint: temp_t'(TEMP_MIN), hysteresis: '0,
                      alarm_threshold: temp_t'(TEMP_MIN), stale_timeout: '0,
                      enable_flag: 1'b0, active_from_input: 1'b0,
                      setpoint_from_input: 1'b0, dedicated_sensor: 1'b0};
            else if (p == 1)
                s = '{setpoint: temp_t'(TEMP_MAX), hysteresis: '1,
                      alarm_threshold: temp_t'(TEMP_MAX), stale_timeout: '1,
                      enable_flag: 1'b1, active_from_input: 1'b1,
                      setpoint_from_input: 1'b1, dedicated_sensor: 1'b1};
            else
                s = rand_settings();
            reconfigure(s);
            idling = (p % 4 != 3);
            repeat ((p < 2) ? 60 : 170) send_word(rand_tick());
        end
        idling = 1'b1;
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure();
        reconfigure(RESET_SETTINGS);
        idling       = 1'b0;
        hold_request = 1'b1;
        repeat (60) send_word(rand_tick());
        idling = 1'b1;
    endtask

    // Result side readiness, with short and long stalls and one requested hold.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
                out_ready   <= 1'b0;
            end
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    stall_left = n - 1;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Register writes update the predictor copy.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SETPOINT:            settings.setpoint = cfg_data[TW-1:0];
                REG_HYSTERESIS:          settings.hysteresis = cfg_data[HYST_WIDTH-1:0];
                REG_ALARM_THRESHOLD:     settings.alarm_threshold = cfg_data[TW-1:0];
                REG_STALE_TIMEOUT:       settings.stale_timeout = cfg_data[AGE_WIDTH-1:0];
                REG_ENABLE_FLAG:         settings.enable_flag = cfg_data[0];
                REG_ACTIVE_FROM_INPUT:   settings.active_from_input = cfg_data[0];
                REG_SETPOINT_FROM_INPUT: settings.setpoint_from_input = cfg_data[0];
                REG_DEDICATED_SENSOR:    settings.dedicated_sensor = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Each accepted tick queues its expected result word.
    always @(posedge clk)
    begin
        tick_t w;
        if (rst_n && in_valid && in_ready)
        begin
            w.temperature       = temperature;
            w.temp_valid        = temp_valid;
            w.sensor_seen       = sensor_seen;
            w.sensor_age        = sensor_age;
            w.active_level      = active_level;
            w.external_setpoint = external_setpoint;
            pending_verdicts.push_back(next_verdict(w));
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("relay_on", want.relay_on, relay_on);
                check_field("relay_changed", want.relay_changed, relay_changed);
                check_field("cause", want.cause, cause);
                check_field("used_setpoint", want.used_setpoint, used_setpoint);
                check_field("publish_temp", want.publish_temp, publish_temp);
                check_field("publish_setpoint", want.publish_setpoint, publish_setpoint);
                check_field("publish_mode", want.publish_mode, publish_mode);
            end
        end
    end

    // Ends the run when no word moves on any channel for too long.
    initial
    begin
        while (quiet_cycles < QUIET_MAX)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no word moved for %0d cycles", QUIET_MAX);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_control_band();
        test_dedicated_sensor();
        test_input_selectors();
        test_random_phases();
        test_output_backpressure();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
